/* hw/rtl/tach_pkg.sv */
// ----------------------------------------------------------------------------
// Tachometer package
// Opcodes, register indexes, field widths and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package tach_pkg;

    // Field widths fixed by the item and register formats.
    localparam int OPCODE_W  = 2;
    localparam int RPM_W     = 20;
    localparam int AVG_OUT_W = 16;
    localparam int MINP_W    = 16;
    localparam int SCALE_W   = 20;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 20;

    // Item opcodes.
    localparam logic [OPCODE_W-1:0] OP_TICK = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_IRQ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_EVAL = 2'd2;

    // Encoder level that records a period.
    localparam logic LEVEL_RECORD = 1'b0;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RPM_SCALE  = 1'd1;

    // Register reset values.
    localparam logic [MINP_W-1:0]  MIN_PERIOD_RST = 16'd50;
    localparam logic [SCALE_W-1:0] RPM_SCALE_RST  = 20'd7500;

    // Controller to datapath commands.
    typedef struct packed {
        logic apply;          // apply the accepted item to the state
        logic acc_step;       // add one ring slot to the sum
        logic div_start_rpm;  // start rpm_scale / average
        logic latch_avg;      // capture the ring average from the sum
        logic speed_zero;     // clear the speed register
        logic speed_load;     // load the speed register from the quotient
        logic out_load;       // load the result register
    } t_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic sweep_last;     // the sum is at its last ring slot
        logic div_done;       // divider quotient is ready
        logic below;          // average is zero or below min_period
        logic is_eval;        // the item in progress is an evaluation
        logic out_free;       // the result register can take a new result
    } t_stat;

endpackage

/* hw/rtl/tach_in_if.sv */
// ----------------------------------------------------------------------------
// Tachometer input channel
// Valid/ready channel carrying one tachometer item.
// ----------------------------------------------------------------------------
interface tach_in_if;
    logic                          valid;
    logic                          ready;
    logic [tach_pkg::OPCODE_W-1:0] opcode;
    logic                          encoder_level;

    modport source (output valid, output opcode, output encoder_level, input ready);
    modport sink   (input valid, input opcode, input encoder_level, output ready);
endinterface

/* hw/rtl/tach_out_if.sv */
// ----------------------------------------------------------------------------
// Tachometer result channel
// Valid/ready channel carrying one speed result.
// ----------------------------------------------------------------------------
interface tach_out_if;
    logic                           valid;
    logic                           ready;
    logic [tach_pkg::RPM_W-1:0]     rpm;
    logic [tach_pkg::AVG_OUT_W-1:0] average_period;
    logic                           below_threshold;

    modport source (output valid, output rpm, output average_period,
                    output below_threshold, input ready);
    modport sink   (input valid, input rpm, input average_period,
                    input below_threshold, output ready);
endinterface

/* hw/rtl/tach_cfg_if.sv */
// ----------------------------------------------------------------------------
// Tachometer configuration channel
// Valid/ready write channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tach_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tach_pkg::CFG_IDX_W-1:0] index;
    logic [tach_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/tach_div.sv */
// ----------------------------------------------------------------------------
// Tachometer divider
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tach_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DIVISOR_W-1:0]  i_divisor,
    output logic                  o_done,
    output logic [DIVIDEND_W-1:0] o_quotient
);

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  r_busy, n_busy;
    logic                  r_done, n_done;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [DIVISOR_W-1:0]  r_rem, n_rem;
    logic [DIVIDEND_W-1:0] r_quo, n_quo;
    logic [DIVISOR_W-1:0]  r_dvs, n_dvs;

    logic [DIVISOR_W:0]    rem_sh;
    logic [DIVISOR_W+1:0]  diff;
    logic                  borrow;

    assign rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, r_dvs};
    assign borrow = diff[DIVISOR_W+1];

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DIVIDEND_W - 1);
            n_rem  = '0;
            n_quo  = i_dividend;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // The partial remainder stays below the divisor whenever the divisor is nonzero.
            n_rem = borrow ? rem_sh[DIVISOR_W-1:0] : diff[DIVISOR_W-1:0];
            n_quo = {r_quo[DIVIDEND_W-2:0], ~borrow};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* hw/rtl/tach_ctrl.sv */
// ----------------------------------------------------------------------------
// Tachometer controller
// Sequences one item through update, ring sum, averaging, speed division
// and result hand-off.
// ----------------------------------------------------------------------------
module tach_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tach_pkg::t_stat i_stat,
    output tach_pkg::t_cmd  o_cmd
);
    import tach_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SUM      = 3'd1;
    localparam logic [2:0] S_AVG      = 3'd2;
    localparam logic [2:0] S_CHECK    = 3'd3;
    localparam logic [2:0] S_RPM_WAIT = 3'd4;
    localparam logic [2:0] S_STORE    = 3'd5;

    logic [2:0] r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.apply = 1'b1;
                    n_state     = S_SUM;
                end
            end
            S_SUM: begin
                o_cmd.acc_step = 1'b1;
                if (i_stat.sweep_last) begin
                    n_state = S_AVG;
                end
            end
            S_AVG: begin
                o_cmd.latch_avg = 1'b1;
                n_state         = S_CHECK;
            end
            S_CHECK: begin
                if (!i_stat.is_eval) begin
                    n_state = S_STORE;
                end else if (i_stat.below) begin
                    o_cmd.speed_zero = 1'b1;
                    n_state          = S_STORE;
                end else begin
                    o_cmd.div_start_rpm = 1'b1;
                    n_state             = S_RPM_WAIT;
                end
            end
            S_RPM_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.speed_load = 1'b1;
                    n_state          = S_STORE;
                end
            end
            S_STORE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* hw/rtl/tach_dp.sv */
// ----------------------------------------------------------------------------
// Tachometer datapath
// Configuration registers, millisecond count, period ring, ring sum and
// average, speed divider, speed register and result register.
// ----------------------------------------------------------------------------
module tach_dp #(
    parameter int SAMPLES     = 4,
    parameter int PERIOD_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tach_pkg::t_cmd                    i_cmd,
    output tach_pkg::t_stat                   o_stat,
    input  logic [tach_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic                              i_level,
    tach_cfg_if.sink                          i_cfg,
    tach_out_if.source                        o_result
);
    import tach_pkg::*;

    localparam int IDX_W = $clog2(SAMPLES);
    localparam int SUM_W = PERIOD_BITS + $clog2(SAMPLES);
    localparam int CMP_W = (PERIOD_BITS > MINP_W) ? PERIOD_BITS : MINP_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SAMPLES - 1);
    localparam bit AVG_POW2 = ((SAMPLES & (SAMPLES - 1)) == 0);

    logic [MINP_W-1:0]      r_min_period;
    logic [SCALE_W-1:0]     r_rpm_scale;
    logic [PERIOD_BITS-1:0] r_elapsed;
    logic [PERIOD_BITS-1:0] r_ring [SAMPLES];
    logic [IDX_W-1:0]       r_index;
    logic                   r_is_eval;
    logic [IDX_W-1:0]       r_sweep_idx;
    logic [SUM_W-1:0]       r_sum;
    logic [PERIOD_BITS-1:0] r_avg;
    logic [RPM_W-1:0]       r_speed;
    logic                   r_out_valid;
    logic [RPM_W-1:0]       r_out_rpm;
    logic [AVG_OUT_W-1:0]   r_out_avg;
    logic                   r_out_below;

    logic                   is_tick, is_rec, is_eval;
    logic                   div_done;
    logic [SCALE_W-1:0]     div_quotient;
    logic [PERIOD_BITS-1:0] sum_avg;
    logic [CMP_W-1:0]       avg_cmp, minp_cmp;
    logic                   below;

    // Configuration writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_period <= MIN_PERIOD_RST;
            r_rpm_scale  <= RPM_SCALE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_MIN_PERIOD: r_min_period <= i_cfg.data[MINP_W-1:0];
                REG_RPM_SCALE:  r_rpm_scale  <= i_cfg.data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign is_tick = (i_opcode == OP_TICK);
    assign is_eval = (i_opcode == OP_EVAL);
    assign is_rec  = (i_opcode == OP_IRQ) && (i_level == LEVEL_RECORD);

    // Item update: count, ring slot and ring index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_index   <= '0;
            r_is_eval <= 1'b0;
            for (int i = 0; i < SAMPLES; i++) begin
                r_ring[i] <= '0;
            end
        end else if (i_cmd.apply) begin
            r_is_eval <= is_eval;
            if (is_tick && (r_elapsed != '1)) begin
                r_elapsed <= r_elapsed + 1'b1;
            end
            if (is_rec || is_eval) begin
                r_ring[r_index] <= r_elapsed;
            end
            if (is_rec) begin
                r_elapsed <= '0;
                r_index   <= (r_index == IDX_LAST) ? '0 : r_index + 1'b1;
            end
        end
    end

    // Ring sum, one slot per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            r_sum       <= '0;
            r_sweep_idx <= '0;
        end else if (i_cmd.acc_step) begin
            r_sum       <= r_sum + SUM_W'(r_ring[r_sweep_idx]);
            r_sweep_idx <= r_sweep_idx + 1'b1;
        end
    end

    // Ring average: a shift when the ring size is a power of two, otherwise
    // an exact multiplication by the rounded-up reciprocal of the ring size.
    if (AVG_POW2) begin : g_avg_shift
        assign sum_avg = r_sum[SUM_W-1:IDX_W];
    end else begin : g_avg_rcp
        localparam int RCP_SH = SUM_W + IDX_W;
        localparam int RCP_W  = SUM_W + 1;
        localparam int PROD_W = SUM_W + RCP_W;
        localparam longint unsigned RCP_M =
            ((64'd1 << RCP_SH) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
        logic [PROD_W-1:0] rcp_prod;
        assign rcp_prod = PROD_W'(r_sum) * PROD_W'(RCP_W'(RCP_M));
        assign sum_avg  = rcp_prod[RCP_SH +: PERIOD_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_avg) begin
            r_avg <= sum_avg;
        end
    end

    tach_div #(
        .DIVIDEND_W (SCALE_W),
        .DIVISOR_W  (PERIOD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start_rpm),
        .i_dividend (r_rpm_scale),
        .i_divisor  (r_avg),
        .o_done     (div_done),
        .o_quotient (div_quotient)
    );

    assign avg_cmp  = CMP_W'(r_avg);
    assign minp_cmp = CMP_W'(r_min_period);
    assign below    = (r_avg == '0) || (avg_cmp < minp_cmp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed <= '0;
        end else if (i_cmd.speed_zero) begin
            r_speed <= '0;
        end else if (i_cmd.speed_load) begin
            r_speed <= div_quotient[RPM_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out_rpm   <= r_speed;
            r_out_avg   <= avg_cmp[AVG_OUT_W-1:0];
            r_out_below <= below;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.rpm             = r_out_rpm;
    assign o_result.average_period  = r_out_avg;
    assign o_result.below_threshold = r_out_below;

    assign o_stat.sweep_last = (r_sweep_idx == IDX_LAST);
    assign o_stat.div_done   = div_done;
    assign o_stat.below      = below;
    assign o_stat.is_eval    = r_is_eval;
    assign o_stat.out_free   = !r_out_valid || o_result.ready;

endmodule

/* hw/rtl/encoder_period_tachometer_top.sv */
// ----------------------------------------------------------------------------
// Encoder period tachometer
// Period-averaging speed measurement for one motor encoder channel.
// ----------------------------------------------------------------------------
// Each input item is a millisecond tick, an encoder interrupt or an evaluate
// request, and each one produces exactly one result: the current speed in
// rpm, the truncated mean of the SAMPLES stored periods and a flag that is
// set when that mean is zero or below min_period. Only an evaluate item
// changes the speed; it first writes the running count into the current
// ring slot. Items are handled one at a time. A tick, an interrupt or an
// evaluation that ends below the threshold goes from its transfer to a
// valid result through the ring sum, which reads one slot per cycle, the
// forming of the average from the sum, the compare with min_period and
// the load of the result register. An evaluation above the threshold also
// runs the restoring divider for rpm_scale / average, which yields one
// quotient bit per cycle over the 20 bits of rpm_scale. The input is ready
// again in the cycle after the result is loaded, so the next item may start
// while an earlier result still waits for its transfer; that next item then
// holds in the controller, and keeps the input closed, until the output
// register frees. Configuration writes are taken at any time but should
// only be made while the block is idle.
// ----------------------------------------------------------------------------
module encoder_period_tachometer_top #(
    parameter int SAMPLES     = 4,
    parameter int PERIOD_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    tach_in_if.sink    i_item,
    tach_out_if.source o_result,
    tach_cfg_if.sink   i_cfg
);
    import tach_pkg::*;

    t_cmd  cmd;
    t_stat stat;
    logic  in_ready;

    // The controller owns the input handshake; the datapath applies the
    // item payload on the transfer cycle.
    assign i_item.ready = in_ready;

    tach_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    tach_dp #(
        .SAMPLES     (SAMPLES),
        .PERIOD_BITS (PERIOD_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .i_opcode (i_item.opcode),
        .i_level  (i_item.encoder_level),
        .i_cfg    (i_cfg),
        .o_result (o_result)
    );

    // Only one item is in flight: a transfer closes the input next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in progress");

    // A new result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result register overwritten");

    // The speed register changes only while an evaluation is in progress.
    a_speed_on_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.speed_load || cmd.speed_zero) |-> stat.is_eval)
        else $error("speed updated outside an evaluation");

endmodule

/* dv/tach_speed_monitor.sv */
// ----------------------------------------------------------------------------
// Tachometer speed monitor
// Watches the item, result and register channels of the tachometer. It
// keeps its own copy of the period ring and registers, works out the result
// of every accepted item and compares each returned result against it.
// ----------------------------------------------------------------------------
module tach_speed_monitor (
    input  logic i_clk,
    input  logic i_rst_n,
    tach_in_if   i_item,
    tach_out_if  i_result,
    tach_cfg_if  i_cfg,
    output int   o_failures,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tach_pkg::*;

    localparam int SLOTS       = 4;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [RPM_W-1:0]     rpm;
        logic [AVG_OUT_W-1:0] average_period;
        logic                 below_threshold;
    } speed_result_t;

    logic [MINP_W-1:0]  min_period;
    logic [SCALE_W-1:0] rpm_scale;
    logic [15:0]        elapsed_ms;
    logic [15:0]        period_slots [SLOTS];
    logic [1:0]         slot_idx;
    logic [RPM_W-1:0]   speed;
    speed_result_t      speed_results_q [$];
    int                 failures = 0;

    function automatic logic [15:0] slot_mean();
        logic [17:0] sum;
        sum = '0;
        for (int i = 0; i < SLOTS; i++) sum += period_slots[i];
        return sum[17:2];
    endfunction

    function automatic logic too_slow(logic [15:0] mean);
        return (mean == 0) || (mean < min_period);
    endfunction

    // Applies one item to the local state and returns the result it gives.
    function automatic speed_result_t step_tachometer(logic [OPCODE_W-1:0] op, logic lvl);
        speed_result_t r;
        logic [15:0]   mean;
        case (op)
            OP_TICK: begin
                if (elapsed_ms != 16'hFFFF) elapsed_ms++;
            end
            OP_IRQ: begin
                if (lvl == LEVEL_RECORD) begin
                    period_slots[slot_idx] = elapsed_ms;
                    elapsed_ms = '0;
                    slot_idx++;
                end
            end
            OP_EVAL: begin
                period_slots[slot_idx] = elapsed_ms;
                mean = slot_mean();
                if (too_slow(mean)) speed = '0;
                else speed = RPM_W'(rpm_scale / mean);
            end
            default: ;
        endcase
        mean = slot_mean();
        r.rpm             = speed;
        r.average_period  = mean;
        r.below_threshold = too_slow(mean);
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        speed_result_t got;
        speed_result_t want;
        if (!i_rst_n) begin
            min_period = MIN_PERIOD_RST;
            rpm_scale  = RPM_SCALE_RST;
            elapsed_ms = '0;
            for (int i = 0; i < SLOTS; i++) period_slots[i] = '0;
            slot_idx   = '0;
            speed      = '0;
            speed_results_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_MIN_PERIOD: min_period = i_cfg.data[MINP_W-1:0];
                    REG_RPM_SCALE:  rpm_scale  = i_cfg.data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (i_result.valid && i_result.ready) begin
                got.rpm             = i_result.rpm;
                got.average_period  = i_result.average_period;
                got.below_threshold = i_result.below_threshold;
                if (speed_results_q.size() == 0) begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                        $display("%0t: result with none outstanding: rpm %0d avg %0d below %0b",
                                 $realtime, got.rpm, got.average_period, got.below_threshold);
                end else begin
                    want = speed_results_q.pop_front();
                    if (got !== want) begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                            $display({"%0t: result mismatch: rpm exp %0d got %0d, ",
                                      "avg exp %0d got %0d, below exp %0b got %0b"},
                                     $realtime, want.rpm, got.rpm,
                                     want.average_period, got.average_period,
                                     want.below_threshold, got.below_threshold);
                    end
                end
            end
            if (i_item.valid && i_item.ready)
                speed_results_q.push_back(step_tachometer(i_item.opcode, i_item.encoder_level));
        end
        o_failures <= failures;
        o_pending  <= speed_results_q.size();
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// Encoder period tachometer testbench
// Drives ticks, encoder interrupts and evaluations into the tachometer
// under changing register settings and random flow control, while a
// separate monitor predicts every result and compares it.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tach_pkg::*;

    // The one opcode the block defines no action for.
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    localparam int     RANDOM_ITEMS   = 1600;
    localparam int     HOLD_CYCLES    = 400;
    localparam int     SETTLE_CYCLES  = 60;
    localparam longint TIMEOUT_NS     = 100_000_000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // Idle percentages for the sender and the receiver, set per phase.
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;

    // The stimulus flips hold_toggle to ask the receiver for a long hold-off.
    logic hold_toggle = 1'b0;
    logic hold_seen   = 1'b0;
    int   hold_left   = 0;

    int failures;
    int pending;
    int items_sent = 0;

    tach_in_if  item_ch ();
    tach_out_if result_ch ();
    tach_cfg_if cfg_ch ();

    encoder_period_tachometer_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch),
        .i_cfg    (cfg_ch)
    );

    tach_speed_monitor speed_monitor (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .i_result   (result_ch),
        .i_cfg      (cfg_ch),
        .o_failures (failures),
        .o_pending  (pending)
    );

    always #5 i_clk = ~i_clk;

    // Result receiver. Normally it drops ready at random according to
    // sink_idle_pct. When the stimulus asks for a hold-off, it keeps ready
    // low while hold_left counts down, so that a result backs up in the
    // output register and the block has to stall its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ch.ready <= 1'b0;
            hold_left       <= 0;
        end else if (hold_toggle != hold_seen) begin
            hold_seen       <= hold_toggle;
            hold_left       <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offers one item, idling first at random, and returns at the edge of
    // its transfer. Valid stays high so that a following item can go out
    // back to back; it is only lowered during an idle cycle or a drain.
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic lvl);
        while ($urandom_range(99) < src_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.opcode        <= op;
        item_ch.encoder_level <= lvl;
        do @(posedge i_clk); while (!item_ch.ready);
        items_sent++;
    endtask

    // Stops offering items and waits until every predicted result has come
    // back. The monitor's count is registered, so drain first waits for an
    // edge; the first check then already includes the last transfer.
    task automatic drain();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Both registers are only written while the block has nothing in flight.
    task automatic set_config(input logic [MINP_W-1:0] minp, input logic [SCALE_W-1:0] scale);
        write_reg(REG_MIN_PERIOD, CFG_DAT_W'(minp));
        write_reg(REG_RPM_SCALE, CFG_DAT_W'(scale));
    endtask

    function automatic logic [OPCODE_W-1:0] OP_OPCODE_ANY();
        return OPCODE_W'($urandom);
    endfunction

    // One encoder period: a run of ticks, mostly ended by a recording
    // interrupt, sometimes by a glitch or an unused opcode, with
    // evaluations sprinkled in and often one at the end.
    task automatic send_period();
        int n;
        int pick;
        pick = $urandom_range(99);
        if (pick < 20) n = $urandom_range(5);
        else if (pick < 90) n = $urandom_range(70);
        else n = $urandom_range(250, 71);
        repeat (n) begin
            send_item(OP_TICK, 1'($urandom_range(1)));
            if ($urandom_range(99) < 3) send_item(OP_EVAL, 1'($urandom_range(1)));
        end
        pick = $urandom_range(99);
        if (pick < 80) send_item(OP_IRQ, LEVEL_RECORD);
        else if (pick < 90) send_item(OP_IRQ, ~LEVEL_RECORD);
        else if (pick < 95) send_item(OP_SPARE, 1'($urandom_range(1)));
        else send_item(OP_OPCODE_ANY(), 1'($urandom_range(1)));
        if ($urandom_range(99) < 40) send_item(OP_EVAL, 1'($urandom_range(1)));
    endtask

    initial begin
        int seg_end;

        // Every item and register input is known from the first moment.
        item_ch.valid         <= 1'b0;
        item_ch.opcode        <= OP_TICK;
        item_ch.encoder_level <= 1'b0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.index          <= REG_MIN_PERIOD;
        cfg_ch.data           <= '0;

        // Synchronous reset, held from the start and asserted only here.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 19;
        sink_idle_pct = 82;

        // Directed part. An evaluation on the empty ring gives a zero mean,
        // which must be flagged. The unused opcode and an interrupt with the
        // pin high must change nothing, yet still give a result.
        send_item(OP_EVAL, 1'b1);
        send_item(OP_SPARE, 1'b1);
        send_item(OP_SPARE, 1'b0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_IRQ, ~LEVEL_RECORD);
        // Fill every slot with a one millisecond period, leaving the running
        // count at one as well, so that the mean is exactly one.
        repeat (4) begin
            send_item(OP_IRQ, LEVEL_RECORD);
            send_item(OP_TICK, 1'b0);
        end
        send_item(OP_EVAL, 1'b0);
        // A mean of one over the largest scale gives the largest speed.
        drain();
        set_config(16'd0, '1);
        send_item(OP_EVAL, 1'b1);
        // The largest threshold flags everything.
        drain();
        write_reg(REG_MIN_PERIOD, CFG_DAT_W'(16'hFFFF));
        send_item(OP_EVAL, 1'b0);
        // A zero scale must give zero speed without the flag.
        drain();
        set_config(16'd0, '0);
        send_item(OP_EVAL, 1'b1);
        // A mean equal to the threshold is not below it.
        drain();
        set_config(16'd1, 20'd1);
        send_item(OP_EVAL, 1'b0);
        drain();

        // Random part, first phase: the sender seldom idles and the
        // receiver mostly does. Partway through, the receiver holds off for
        // a long stretch while items keep coming.
        set_config(MINP_W'($urandom_range(30)), SCALE_W'($urandom));
        seg_end = items_sent + RANDOM_ITEMS / 3;
        while (items_sent < seg_end) begin
            send_period();
            if (hold_toggle == hold_seen && items_sent > seg_end - RANDOM_ITEMS / 6
                && hold_left == 0 && items_sent < seg_end - 100)
                hold_toggle <= ~hold_toggle;
        end
        drain();

        // Second phase: the roles are swapped. Halfway through, the sender
        // pauses until every result is back, then carries on.
        src_idle_pct  = 82;
        sink_idle_pct = 19;
        set_config(MINP_W'($urandom_range(60)), SCALE_W'($urandom_range(20'hFFFFF, 1)));
        seg_end = items_sent + RANDOM_ITEMS / 3;
        while (items_sent < seg_end - RANDOM_ITEMS / 6) send_period();
        drain();
        while (items_sent < seg_end) send_period();
        drain();

        // Third phase: no idling on either side.
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        set_config(MIN_PERIOD_RST, RPM_SCALE_RST);
        seg_end = items_sent + RANDOM_ITEMS / 3;
        while (items_sent < seg_end) send_period();

        // Let the last results arrive, then a few more cycles for anything
        // the block might still produce on its own.
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run, including every
    // hold-off.
    initial begin
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
